/* rtl/ktt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ktt_pkg;

	// command codes
	localparam logic [1:0] CMD_ARM  = 2'd0;
	localparam logic [1:0] CMD_KILL = 2'd1;
	localparam logic [1:0] CMD_TICK = 2'd2;

	// status codes
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] timer_id;
		logic [31:0] amount;
	} ktt_item_t;

	typedef struct packed {
		logic        expired_valid;
		logic [31:0] expired_id;
		logic        status;
		logic        last;
	} ktt_result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FIND,
		ST_TICK,
		ST_SEL
	} ktt_state_t;

endpackage

`default_nettype wire

/* rtl/keyed_timer_table_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Keyed one-shot timer table.
//
// Channels: an item (command, timer_id, amount) is taken at a rising edge with
// start high and busy low. Results leave on result, qualified by result_valid
// for exactly one cycle each; the receiver has no way to stall them, so it must
// take every strobed result. The result with last set closes each item.
//
// Arm and kill: one scan of the slot table (key compare against timer_id, plus
// lowest-free-slot search), then a single result.
// Tick: a first scan subtracts amount from every running slot, flags those that
// expire and emits the smallest expired key; each further scan emits the
// smallest key still flagged, and a scan that finds none closes the item.
// The cost is set by the single read port of the key/time memories, which
// serves one slot per cycle.
// An unused command returns its result the cycle after it is taken.
// Within one tick, each result follows a full scan of the slot table.
//
// Reset: all slots free and stopped, sequencer idle, no result pending.
// Key and time memories are not cleared; an entry is only looked at once its
// slot has been claimed, so no clearing pass is needed.

module keyed_timer_table_top #(
	parameter int TIMER_SLOTS = 16
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      start,
	output logic                     busy,
	input  ktt_pkg::ktt_item_t       item,
	output logic                     result_valid,
	output ktt_pkg::ktt_result_t     result
);

	localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam logic [IW-1:0] LAST = IW'(TIMER_SLOTS - 1);

	// sequencer and item
	ktt_pkg::ktt_state_t state_q, state_d;
	ktt_pkg::ktt_item_t  cmd_q, cmd_d;

	// scan address generator
	logic [IW-1:0] addr_q, addr_d;
	logic          issue_q, issue_d;

	// read stage
	logic          vld_s1, vld_s1_d;
	logic [IW-1:0] idx_s1, idx_s1_d;
	logic [31:0]   key_s1, rem_s1;

	// per-slot flags
	logic [TIMER_SLOTS-1:0] used_q, used_d;
	logic [TIMER_SLOTS-1:0] run_q, run_d;
	logic [TIMER_SLOTS-1:0] pend_q, pend_d;   // expired on this tick, not yet reported

	// scan results
	logic          hit_q, hit_d;
	logic [IW-1:0] hit_idx_q, hit_idx_d;
	logic          free_q, free_d;
	logic [IW-1:0] free_idx_q, free_idx_d;
	logic          best_q, best_d;
	logic [31:0]   best_key_q, best_key_d;
	logic [IW-1:0] best_idx_q, best_idx_d;

	// result register
	ktt_pkg::ktt_result_t out_q, out_d;
	logic                 out_vld_q, out_vld_d;

	// memory write port
	logic          key_we, rem_we;
	logic [IW-1:0] wr_idx;
	logic [31:0]   rem_wd;

	logic pass_end;

	// slot memories: one write, one registered read per cycle
	logic [31:0] slot_key_q [TIMER_SLOTS];
	logic [31:0] slot_rem_q [TIMER_SLOTS];

	always_ff @(posedge clk) begin
		if (key_we) begin
			slot_key_q[wr_idx] <= cmd_q.timer_id;
		end
		if (rem_we) begin
			slot_rem_q[wr_idx] <= rem_wd;
		end
		key_s1 <= slot_key_q[addr_q];
		rem_s1 <= slot_rem_q[addr_q];
	end

	assign busy         = (state_q != ktt_pkg::ST_IDLE);
	assign result_valid = out_vld_q;
	assign result       = out_q;
	assign pass_end     = vld_s1 && (idx_s1 == LAST);

	always_comb begin
		state_d    = state_q;
		cmd_d      = cmd_q;
		addr_d     = addr_q;
		issue_d    = issue_q;
		vld_s1_d   = 1'b0;
		idx_s1_d   = idx_s1;
		used_d     = used_q;
		run_d      = run_q;
		pend_d     = pend_q;
		hit_d      = hit_q;
		hit_idx_d  = hit_idx_q;
		free_d     = free_q;
		free_idx_d = free_idx_q;
		best_d     = best_q;
		best_key_d = best_key_q;
		best_idx_d = best_idx_q;
		out_d      = out_q;
		out_vld_d  = 1'b0;
		key_we     = 1'b0;
		rem_we     = 1'b0;
		wr_idx     = idx_s1;
		rem_wd     = rem_s1 - cmd_q.amount;

		// slot address walks 0..LAST once per scan
		if (state_q != ktt_pkg::ST_IDLE && issue_q) begin
			vld_s1_d = 1'b1;
			idx_s1_d = addr_q;
			if (addr_q == LAST) begin
				issue_d = 1'b0;
			end else begin
				addr_d = addr_q + 1'b1;
			end
		end

		case (state_q)
			ktt_pkg::ST_IDLE: begin
				if (start) begin
					cmd_d   = item;
					addr_d  = '0;
					issue_d = 1'b1;
					hit_d   = 1'b0;
					free_d  = 1'b0;
					best_d  = 1'b0;
					case (item.command)
						ktt_pkg::CMD_ARM:  state_d = ktt_pkg::ST_FIND;
						ktt_pkg::CMD_KILL: state_d = ktt_pkg::ST_FIND;
						ktt_pkg::CMD_TICK: state_d = ktt_pkg::ST_TICK;
						default: begin
							// unused command: acknowledge at once
							issue_d             = 1'b0;
							out_vld_d           = 1'b1;
							out_d.expired_valid = 1'b0;
							out_d.expired_id    = '0;
							out_d.status        = ktt_pkg::STATUS_OK;
							out_d.last          = 1'b1;
						end
					endcase
				end
			end

			ktt_pkg::ST_FIND: begin
				if (vld_s1) begin
					if (used_q[idx_s1] && key_s1 == cmd_q.timer_id && !hit_q) begin
						hit_d     = 1'b1;
						hit_idx_d = idx_s1;
					end
					if (!used_q[idx_s1] && !free_q) begin
						free_d     = 1'b1;
						free_idx_d = idx_s1;
					end
				end
				if (pass_end) begin
					state_d             = ktt_pkg::ST_IDLE;
					out_vld_d           = 1'b1;
					out_d.expired_valid = 1'b0;
					out_d.expired_id    = '0;
					out_d.status        = ktt_pkg::STATUS_OK;
					out_d.last          = 1'b1;
					if (cmd_q.command == ktt_pkg::CMD_ARM) begin
						rem_wd = cmd_q.amount;
						if (hit_d) begin
							run_d[hit_idx_d] = 1'b1;
							wr_idx           = hit_idx_d;
							rem_we           = 1'b1;
						end else if (free_d) begin
							used_d[free_idx_d] = 1'b1;
							run_d[free_idx_d]  = 1'b1;
							wr_idx             = free_idx_d;
							key_we             = 1'b1;
							rem_we             = 1'b1;
						end else begin
							out_d.status = ktt_pkg::STATUS_FULL;
						end
					end else if (hit_d) begin
						used_d[hit_idx_d] = 1'b0;
						run_d[hit_idx_d]  = 1'b0;
					end
				end
			end

			ktt_pkg::ST_TICK: begin
				if (vld_s1 && used_q[idx_s1] && run_q[idx_s1]) begin
					rem_we = 1'b1;
					if (rem_s1 <= cmd_q.amount) begin
						run_d[idx_s1]  = 1'b0;
						pend_d[idx_s1] = 1'b1;
						if (!best_q || key_s1 < best_key_q) begin
							best_d     = 1'b1;
							best_key_d = key_s1;
							best_idx_d = idx_s1;
						end
					end
				end
			end

			ktt_pkg::ST_SEL: begin
				if (vld_s1 && pend_q[idx_s1] && (!best_q || key_s1 < best_key_q)) begin
					best_d     = 1'b1;
					best_key_d = key_s1;
					best_idx_d = idx_s1;
				end
			end

			default: begin
				state_d = ktt_pkg::ST_IDLE;
			end
		endcase

		// end of a tick scan: report the smallest pending key, or close
		if (pass_end && (state_q == ktt_pkg::ST_TICK || state_q == ktt_pkg::ST_SEL)) begin
			out_vld_d    = 1'b1;
			out_d.status = ktt_pkg::STATUS_OK;
			if (best_d) begin
				out_d.expired_valid = 1'b1;
				out_d.expired_id    = best_key_d;
				out_d.last          = 1'b0;
				pend_d[best_idx_d]  = 1'b0;
				best_d              = 1'b0;
				addr_d              = '0;
				issue_d             = 1'b1;
				state_d             = ktt_pkg::ST_SEL;
			end else begin
				out_d.expired_valid = 1'b0;
				out_d.expired_id    = '0;
				out_d.last          = 1'b1;
				state_d             = ktt_pkg::ST_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ktt_pkg::ST_IDLE;
			addr_q    <= '0;
			issue_q   <= 1'b0;
			vld_s1    <= 1'b0;
			used_q    <= '0;
			run_q     <= '0;
			pend_q    <= '0;
			hit_q     <= 1'b0;
			free_q    <= 1'b0;
			best_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			addr_q    <= addr_d;
			issue_q   <= issue_d;
			vld_s1    <= vld_s1_d;
			used_q    <= used_d;
			run_q     <= run_d;
			pend_q    <= pend_d;
			hit_q     <= hit_d;
			free_q    <= free_d;
			best_q    <= best_d;
			out_vld_q <= out_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q      <= cmd_d;
		idx_s1     <= idx_s1_d;
		hit_idx_q  <= hit_idx_d;
		free_idx_q <= free_idx_d;
		best_key_q <= best_key_d;
		best_idx_q <= best_idx_d;
		out_q      <= out_d;
	end

	// every expired timer has been reported before the sequencer goes idle
	a_pend_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ktt_pkg::ST_IDLE |-> pend_q == '0)
		else $error("pending expiries left while idle");

	// the closing result and the return to idle happen together
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_q.last |-> state_q == ktt_pkg::ST_IDLE)
		else $error("closing result while sequencer still active");

	// an expiry report is always followed by another selection scan
	a_expiry_sel: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !out_q.last |-> state_q == ktt_pkg::ST_SEL && out_q.expired_valid)
		else $error("expiry report outside selection scan");

	// a running timer always owns its slot
	a_run_used: assert property (@(posedge clk) disable iff (!arst_n)
		(run_q & ~used_q) == '0)
		else $error("running timer in a free slot");

endmodule

`default_nettype wire
